// ----- hdl/ktt_pkg.sv -----
// ktt_pkg: opcodes, status codes, register indices and the shared command type of the keyed timer table.
// No dependencies.
package ktt_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_PAUSE   = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;
    localparam logic [2:0] OP_RESTART = 3'd5;
    localparam logic [2:0] OP_QUERY   = 3'd6;
    localparam logic [2:0] OP_NONE    = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_PAUSE = 2'd1;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    // command passed from front to back through the queue
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] dur;
        logic        rep;
        logic        rt;
        logic [31:0] delta;
    } t_cmd;

endpackage

// ----- hdl/ktt_front.sv -----
// ktt_front: input stage and two-entry command queue toward the back end.
// Depends on ktt_pkg.
module ktt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ktt_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output ktt_pkg::t_cmd  o_cmd
);
    import ktt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule

// ----- hdl/ktt_divider.sv -----
// ktt_divider: 32-bit remainder unit, one quotient bit per cycle.
// Depends on nothing.
module ktt_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [31:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;

    assign w_sh   = {r_rem[31:0], r_num[31]};
    assign o_rem  = r_rem[31:0];
    assign o_done = r_busy && (r_cnt == 6'd32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= 33'd0;
        end else if (r_busy && r_cnt != 6'd32) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
        end
    end
endmodule

// ----- hdl/ktt_back.sv -----
// ktt_back: slot table and sequencer that walks slots for tick and key search.
// Depends on ktt_pkg and ktt_divider.
module ktt_back #(
    parameter int NUM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ktt_pkg::t_cmd  i_cmd,
    input  logic [15:0]    i_scale,
    input  logic           i_gpause,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic           o_fired,
    output logic [3:0]     o_slot_index,
    output logic [31:0]    o_result_key,
    output logic [47:0]    o_time_value,
    output logic           o_last
);
    import ktt_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_TICK  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FIND  = 7'b0010000,
        S_EXEC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_st;
    t_cmd   r_cmd;

    logic [31:0] r_id   [NUM_SLOTS];
    logic [31:0] r_per  [NUM_SLOTS];
    logic [31:0] r_el   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_act, r_pau, r_loop, r_real;
    logic [47:0] r_rtot, r_gtot;
    logic [39:0] r_gd;

    logic [SW:0]   r_idx;
    logic [SW-1:0] w_i;
    logic          r_fnd, r_fre;
    logic [SW-1:0] r_fi, r_ri;

    logic        r_ov;
    logic [1:0]  r_ostat;
    logic        r_ofire, r_olast;
    logic [3:0]  r_oslot;
    logic [31:0] r_okey;
    logic [47:0] r_otv;

    logic [40:0] w_e;
    logic [31:0] w_es;
    logic [48:0] w_rs, w_gs;
    logic        w_dstart, w_ddone;
    logic [31:0] w_drem;
    logic        w_out_free, w_end;

    assign w_i = r_idx[SW-1:0];
    assign w_end = (r_idx == (SW+1)'(NUM_SLOTS - 1));
    assign w_out_free = !r_ov || i_ready;
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_ostat;
    assign o_fired = r_ofire;
    assign o_slot_index = r_oslot;
    assign o_result_key = r_okey;
    assign o_time_value = r_otv;
    assign o_last = r_olast;

    assign w_e  = {9'd0, r_el[w_i]} + (r_real[w_i] ? {9'd0, r_cmd.delta} : {1'b0, r_gd});
    assign w_es = w_e[40:32] != 9'd0 ? 32'hFFFF_FFFF : w_e[31:0];
    assign w_rs = {1'b0, r_rtot} + {17'd0, r_cmd.delta};
    assign w_gs = {1'b0, r_gtot} + {9'd0, r_gd};
    assign w_dstart = (r_st == S_TICK) && r_act[w_i] && !r_pau[w_i] && w_out_free
                      && (w_es >= r_per[w_i]) && r_loop[w_i] && (r_per[w_i] != 32'd0);

    ktt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_es),
        .i_den   (r_per[w_i]),
        .o_done  (w_ddone),
        .o_rem   (w_drem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_ov   <= 1'b0;
            r_act  <= '0;
            r_pau  <= '0;
            r_loop <= '0;
            r_real <= '0;
            r_rtot <= 48'd0;
            r_gtot <= 48'd0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_id[k]  <= 32'd0;
                r_per[k] <= 32'd0;
                r_el[k]  <= 32'd0;
            end
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_fnd <= 1'b0;
                        r_fre <= 1'b0;
                        r_st  <= (i_cmd.op == OP_TICK) ? S_SCALE : S_FIND;
                    end
                end
                S_SCALE: begin
                    r_gd <= i_gpause ? 40'd0
                          : 40'(({32'd0, r_cmd.delta} * {48'd0, i_scale}) >> 8);
                    r_st <= S_TICK;
                end
                S_TICK: begin
                    if (w_out_free) begin
                        if (r_idx == '0) begin
                            r_rtot <= w_rs[48] ? MAX48 : w_rs[47:0];
                            r_gtot <= w_gs[48] ? MAX48 : w_gs[47:0];
                        end
                        if (r_idx == (SW+1)'(NUM_SLOTS)) begin
                            r_ov <= 1'b1; r_ostat <= ST_OK; r_ofire <= 1'b0;
                            r_oslot <= 4'd0; r_okey <= 32'd0; r_otv <= r_gtot;
                            r_olast <= 1'b1; r_st <= S_IDLE;
                        end else if (r_act[w_i] && !r_pau[w_i]) begin
                            r_el[w_i] <= w_es;
                            if (w_es >= r_per[w_i]) begin
                                r_ov <= 1'b1; r_ostat <= ST_OK; r_ofire <= 1'b1;
                                r_oslot <= 4'(w_i); r_okey <= r_id[w_i];
                                r_otv <= 48'd0; r_olast <= 1'b0;
                                if (!r_loop[w_i]) begin
                                    r_id[w_i] <= 32'd0; r_per[w_i] <= 32'd0;
                                    r_el[w_i] <= 32'd0; r_act[w_i] <= 1'b0;
                                    r_pau[w_i] <= 1'b0; r_real[w_i] <= 1'b0;
                                    r_idx <= r_idx + 1'b1;
                                end else if (r_per[w_i] == 32'd0) begin
                                    r_el[w_i] <= 32'd0;
                                    r_idx <= r_idx + 1'b1;
                                end else begin
                                    r_st <= S_DIV;
                                end
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_el[w_i] <= w_drem;
                        r_idx <= r_idx + 1'b1;
                        r_st  <= S_TICK;
                    end
                end
                S_FIND: begin
                    if (r_cmd.op == OP_NONE || r_cmd.key == 32'd0) begin
                        r_st <= S_EXEC;
                    end else begin
                        if (!r_fnd && r_act[w_i] && r_id[w_i] == r_cmd.key) begin
                            r_fnd <= 1'b1; r_fi <= w_i;
                        end
                        if (!r_fre && !r_act[w_i]) begin
                            r_fre <= 1'b1; r_ri <= w_i;
                        end
                        if (w_end) r_st <= S_EXEC;
                        else r_idx <= r_idx + 1'b1;
                    end
                end
                // result registers are only rewritten once the held beat is gone
                S_EXEC: if (w_out_free) begin
                    r_ofire <= 1'b0; r_olast <= 1'b1;
                    r_oslot <= 4'd0; r_okey <= 32'd0; r_otv <= 48'd0;
                    r_ostat <= ST_OK;
                    r_st <= S_OUT;
                    if (r_cmd.op == OP_NONE) begin
                    end else if (r_cmd.key == 32'd0) begin
                        r_ostat <= ST_INVALID;
                    end else if (r_cmd.op == OP_START) begin
                        if (!r_fnd && !r_fre) begin
                            r_ostat <= ST_FULL;
                        end else begin
                            r_id[r_fnd ? r_fi : r_ri]   <= r_cmd.key;
                            r_per[r_fnd ? r_fi : r_ri]  <= r_cmd.dur;
                            r_el[r_fnd ? r_fi : r_ri]   <= 32'd0;
                            r_act[r_fnd ? r_fi : r_ri]  <= 1'b1;
                            r_pau[r_fnd ? r_fi : r_ri]  <= 1'b0;
                            r_loop[r_fnd ? r_fi : r_ri] <= r_cmd.rep;
                            r_real[r_fnd ? r_fi : r_ri] <= r_cmd.rt;
                            r_oslot <= 4'(r_fnd ? r_fi : r_ri);
                            r_okey  <= r_cmd.key;
                        end
                    end else if (!r_fnd) begin
                        r_ostat <= ST_NOTFOUND;
                    end else begin
                        r_oslot <= 4'(r_fi);
                        unique case (r_cmd.op)
                            OP_STOP: begin
                                r_id[r_fi] <= 32'd0; r_per[r_fi] <= 32'd0;
                                r_el[r_fi] <= 32'd0; r_act[r_fi] <= 1'b0;
                                r_pau[r_fi] <= 1'b0; r_loop[r_fi] <= 1'b0;
                                r_real[r_fi] <= 1'b0;
                            end
                            OP_PAUSE:   r_pau[r_fi] <= 1'b1;
                            OP_RESUME:  r_pau[r_fi] <= 1'b0;
                            OP_RESTART: r_el[r_fi] <= 32'd0;
                            default: begin
                                r_otv <= (r_per[r_fi] > r_el[r_fi])
                                         ? {16'd0, r_per[r_fi] - r_el[r_fi]} : 48'd0;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/keyed_timer_table_core.sv -----
// Keyed timer table: a queue front end feeding a sequenced slot table.
// Start/stop/pause/resume/restart/query walk the slots in a key search (skipped for key 0 or no-op).
// Tick walks all slots and runs the serial remainder unit for each looping expiry with a nonzero period.
// One item in the back end at a time; a held result stalls the walk and the queue.
// Synchronous active-low reset frees all slots, zeroes totals, scale=1.0, pause off.
// Depends on ktt_pkg, ktt_front, ktt_back.
module keyed_timer_table_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_timer_key,
    input  logic [31:0] i_duration,
    input  logic        i_repeat_req,
    input  logic        i_real_time,
    input  logic [31:0] i_delta,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [3:0]  o_slot_index,
    output logic [31:0] o_result_key,
    output logic [47:0] o_time_value,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ktt_pkg::*;

    t_cmd        w_in, w_q;
    logic        w_qv, w_qr;
    logic [15:0] r_scale;
    logic        r_gpause;

    assign w_in = '{op: i_operation, key: i_timer_key, dur: i_duration,
                    rep: i_repeat_req, rt: i_real_time, delta: i_delta};
    assign pready = 1'b1;

    // registers sit at byte addresses 0 and 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 16'd256;
            r_gpause <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr == {REG_SCALE[0], 2'b00}) r_scale <= pwdata[15:0];
            if (paddr == {REG_PAUSE[0], 2'b00}) r_gpause <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == {REG_SCALE[0], 2'b00}) prdata = {16'd0, r_scale};
        else if (paddr == {REG_PAUSE[0], 2'b00}) prdata = {31'd0, r_gpause};
    end

    ktt_front u_front (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (i_valid), .o_ready (o_ready), .i_cmd (w_in),
        .o_valid (w_qv), .i_ready (w_qr), .o_cmd (w_q)
    );

    ktt_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (w_qv), .o_ready (w_qr), .i_cmd (w_q),
        .i_scale (r_scale), .i_gpause (r_gpause),
        .o_valid (o_valid), .i_ready (i_ready),
        .o_status (o_status), .o_fired (o_fired), .o_slot_index (o_slot_index),
        .o_result_key (o_result_key), .o_time_value (o_time_value), .o_last (o_last)
    );
endmodule
